// ===== hdl/lcdr_pkg.sv =====
// lcdr_pkg: shared codes, constants and controller/datapath signal groups
`default_nettype none

package lcdr_pkg;

	// item operation codes
	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_REFRESH = 2'd1,
		OP_POWER   = 2'd2
	} lcdr_op_t;

	// source of the next outgoing byte
	typedef enum logic [1:0] {
		SEL_ADDR = 2'd0,
		SEL_SET  = 2'd1,
		SEL_DATA = 2'd2,
		SEL_MODE = 2'd3
	} lcdr_sel_t;

	localparam logic [7:0] ADDR_RESET      = 8'h7C;
	localparam logic [7:0] MODE_SET_OP     = 8'h40;
	localparam logic [7:0] MODE_DISPLAY_ON = 8'h08;

	// controller to datapath
	typedef struct packed {
		logic      store;
		logic      scan_clr;
		logic      scan_step;
		logic      sync_shadow;
		logic      load_out;
		lcdr_sel_t out_sel;
		logic      out_start;
		logic      out_end;
		logic      data_step;
		logic      toggle_off;
	} lcdr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
		logic dirty_seen;
		logic data_last;
		logic display_off;
		logic out_free;
	} lcdr_stat_t;

endpackage

`default_nettype wire

// ===== hdl/lcdr_in_if.sv =====
// lcdr_in_if: input item channel
`default_nettype none

interface lcdr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [3:0] byte_index;
	logic [7:0] byte_value;

	modport source (output valid, output command, output byte_index, output byte_value,
		input ready);
	modport sink (input valid, input command, input byte_index, input byte_value,
		output ready);
endinterface

`default_nettype wire

// ===== hdl/lcdr_out_if.sv =====
// lcdr_out_if: outgoing link byte channel
`default_nettype none

interface lcdr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       frame_start;
	logic       frame_end;

	modport source (output valid, output tx_byte, output frame_start, output frame_end,
		input ready);
	modport sink (input valid, input tx_byte, input frame_start, input frame_end,
		output ready);
endinterface

`default_nettype wire

// ===== hdl/lcdr_dp.sv =====
// lcdr_dp: frame buffer, shadow, range scan and output byte register
`default_nettype none

module lcdr_dp
	import lcdr_pkg::*;
#(
	parameter int BUFFER_BYTES = 12
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic [3:0] byte_index,
	input  wire logic [7:0] byte_value,
	input  wire lcdr_cmd_t  cmd,
	output lcdr_stat_t      st,
	input  wire logic       out_ready,
	output logic            out_valid,
	output logic [7:0]      tx_byte,
	output logic            frame_start,
	output logic            frame_end
);

	localparam int IDX_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

	logic [7:0]       frame_q  [BUFFER_BYTES];
	logic [7:0]       shadow_q [BUFFER_BYTES];
	logic             display_off_q;
	logic [7:0]       slave_addr_q;
	logic [IDX_W-1:0] ptr_q;
	logic [IDX_W-1:0] first_q;
	logic [IDX_W-1:0] last_q;
	logic             found_q;
	logic             out_valid_q;
	logic [7:0]       tx_q;
	logic             start_q;
	logic             end_q;

	logic             in_range;
	logic             cur_dirty;
	logic [7:0]       next_byte;

	assign in_range  = {1'b0, byte_index} < 5'(BUFFER_BYTES);
	assign cur_dirty = frame_q[ptr_q] != shadow_q[ptr_q];

	always_comb begin
		case (cmd.out_sel)
			SEL_ADDR: next_byte = slave_addr_q;
			SEL_SET:  next_byte = 8'({first_q, 1'b0});
			SEL_DATA: next_byte = frame_q[ptr_q];
			SEL_MODE: next_byte = MODE_SET_OP | (display_off_q ? MODE_DISPLAY_ON : 8'h00);
			default:  next_byte = slave_addr_q;
		endcase
	end

	// buffers, flag and address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUFFER_BYTES; i++) begin
				frame_q[i]  <= 8'h00;
				shadow_q[i] <= 8'h00;
			end
			display_off_q <= 1'b0;
			slave_addr_q  <= ADDR_RESET;
		end else begin
			if (cfg_we) begin
				slave_addr_q <= cfg_wdata;
			end
			if (cmd.store && in_range) begin
				frame_q[byte_index[IDX_W-1:0]] <= byte_value;
			end
			if (cmd.sync_shadow) begin
				for (int i = 0; i < BUFFER_BYTES; i++) begin
					shadow_q[i] <= frame_q[i];
				end
			end
			if (cmd.toggle_off) begin
				display_off_q <= !display_off_q;
			end
		end
	end

	// scan pointer doubles as the data pointer while sending
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			first_q <= '0;
			last_q  <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.scan_clr) begin
				ptr_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				ptr_q <= ptr_q + 1'b1;
				if (cur_dirty) begin
					if (!found_q) begin
						first_q <= ptr_q;
					end
					last_q  <= ptr_q;
					found_q <= 1'b1;
				end
			end else if (cmd.load_out && cmd.out_sel == SEL_SET) begin
				ptr_q <= first_q;
			end else if (cmd.data_step) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// output byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			tx_q    <= next_byte;
			start_q <= cmd.out_start;
			end_q   <= cmd.out_end;
		end
	end

	assign st.scan_last   = ptr_q == IDX_W'(BUFFER_BYTES - 1);
	assign st.dirty_seen  = found_q || cur_dirty;
	assign st.data_last   = ptr_q == last_q;
	assign st.display_off = display_off_q;
	assign st.out_free    = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign tx_byte     = tx_q;
	assign frame_start = start_q;
	assign frame_end   = end_q;

endmodule

`default_nettype wire

// ===== hdl/lcdr_ctrl.sv =====
// lcdr_ctrl: sequencer for item decode, range scan and byte emission
`default_nettype none

module lcdr_ctrl
	import lcdr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_command,
	output logic            in_ready,
	input  wire lcdr_stat_t st,
	output lcdr_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ADDR,
		ST_SET,
		ST_DATA,
		ST_PWR_ADDR,
		ST_PWR_MODE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = state_q == ST_IDLE;
		accept   = in_valid && in_ready;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_command)
						OP_WRITE: begin
							cmd.store = 1'b1;
						end
						OP_REFRESH: begin
							if (!st.display_off) begin
								cmd.scan_clr = 1'b1;
								state_d      = ST_SCAN;
							end
						end
						OP_POWER: begin
							state_d = ST_PWR_ADDR;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.scan_last) begin
					if (st.dirty_seen) begin
						cmd.sync_shadow = 1'b1;
						state_d         = ST_ADDR;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ADDR, ST_PWR_ADDR: begin
				if (st.out_free) begin
					cmd.load_out  = 1'b1;
					cmd.out_sel   = SEL_ADDR;
					cmd.out_start = 1'b1;
					state_d       = (state_q == ST_ADDR) ? ST_SET : ST_PWR_MODE;
				end
			end
			ST_SET: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = SEL_SET;
					state_d      = ST_DATA;
				end
			end
			ST_DATA: begin
				if (st.out_free) begin
					cmd.load_out  = 1'b1;
					cmd.out_sel   = SEL_DATA;
					cmd.out_end   = st.data_last;
					cmd.data_step = 1'b1;
					if (st.data_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_PWR_MODE: begin
				if (st.out_free) begin
					cmd.load_out   = 1'b1;
					cmd.out_sel    = SEL_MODE;
					cmd.out_end    = 1'b1;
					cmd.toggle_off = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lcd_dirty_range_refresh.sv =====
// lcd_dirty_range_refresh: top level, segment buffer with changed-span link refresh
//
//  channel   | dir | handshake      | beat contents
//  ----------+-----+----------------+-----------------------------------------
//  items     | in  | valid / ready  | command, byte_index, byte_value
//  results   | out | valid / ready  | tx_byte, frame_start, frame_end
//  cfg       | in  | cfg_we only    | cfg_wdata -> slave address byte
//
// a frame write is stored as it is taken; a power toggle sends two bytes
// a refresh, dropped while the display is off, scans the buffer and then sends
// address, address-set and changed-span bytes, the scan walking one entry a cycle
// a stalled results sink holds the sequencer at the next byte; the last byte
// waits in the output register while the next item is taken
// reset clears both buffers, the display-off flag and loads the address 0x7C
`default_nettype none

module lcd_dirty_range_refresh
	import lcdr_pkg::*;
#(
	parameter int BUFFER_BYTES = 12
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	lcdr_in_if.sink         items,
	lcdr_out_if.source      results
);

	// command and status between sequencer and datapath
	lcdr_cmd_t  cmd;
	lcdr_stat_t st;

	// sequencer: decodes items and steps the scan and send phases
	lcdr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (items.valid),
		.in_command (items.command),
		.in_ready   (items.ready),
		.st         (st),
		.cmd        (cmd)
	);

	// datapath: buffers, range finder and output byte register
	lcdr_dp #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.byte_index  (items.byte_index),
		.byte_value  (items.byte_value),
		.cmd         (cmd),
		.st          (st),
		.out_ready   (results.ready),
		.out_valid   (results.valid),
		.tx_byte     (results.tx_byte),
		.frame_start (results.frame_start),
		.frame_end   (results.frame_end)
	);

`ifndef SYNTHESIS
	// a pending beat is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> st.out_free)
		else $error("output beat overwritten before taken");

	// opening beat of a transaction is never its closing beat
	a_start_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> !(results.frame_start && results.frame_end))
		else $error("beat marked both start and end");

	// a power toggle closes the item side once its item is taken
	a_power_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready && items.command == OP_POWER) |=> !items.ready)
		else $error("item taken during power transaction");

	// display flag flips exactly when the mode byte is loaded
	a_flag_flip: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.toggle_off |=> st.display_off != $past(st.display_off))
		else $error("display flag did not flip");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_lcd_dirty_range_refresh.sv =====
// tb_lcd_dirty_range_refresh: self-checking testbench, directed table then random items
`timescale 1ns / 1ps

module tb_lcd_dirty_range_refresh;
	import lcdr_pkg::*;

	localparam int BUFFER_BYTES = 12;
	// command code the block leaves unused
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// idling odds out of a hundred
	localparam int IDLE_PCT = 19;
	// random items per address phase
	localparam int ITEMS_PER_PHASE = 72;
	// a result-free refresh still scans the whole buffer, so allow plenty
	localparam int DRAIN_CYCLES = 40;
	// worst case: 14 beats per item, each held up by sink stalls, plus scan and gaps
	localparam int CYCLE_LIMIT = 200000;

	// one byte on the link, as the results channel carries it
	typedef struct packed {
		logic [7:0] tx_byte;
		logic       frame_start;
		logic       frame_end;
	} link_beat_t;

	// one directed row; typed rows carry their own expected beats
	typedef struct packed {
		logic [1:0]       cmd;
		logic [3:0]       idx;
		logic [7:0]       val;
		logic             typed;
		logic [1:0]       n_beats;
		link_beat_t [2:0] beats;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	lcdr_in_if  in_ch ();
	lcdr_out_if out_ch ();

	lcd_dirty_range_refresh #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.items(in_ch),
		.results(out_ch)
	);

	// our own copy of the block state, updated as each item beat is accepted
	logic [7:0] frame_copy [BUFFER_BYTES];
	logic [7:0] shadow_copy [BUFFER_BYTES];
	logic       display_off_copy;
	logic [7:0] slave_addr_copy;

	link_beat_t predicted_bytes [$];     // beats worked out for the latest item
	link_beat_t awaited_link_bytes [$];  // beats still owed by the block, oldest first
	stim_row_t  stim_table [$];

	int  error_count;
	int  cycle_count;
	bit  steady;  // set for a long stretch with no idling on either side

	// clock, 10 ns period
	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic link_beat_t beat(logic [7:0] b, logic s, logic e);
		link_beat_t t;
		t.tx_byte = b;
		t.frame_start = s;
		t.frame_end = e;
		return t;
	endfunction

	// what the block should put on the link for one item, and how its state moves
	function automatic void predict_link_bytes(logic [1:0] cmd, logic [3:0] idx,
		logic [7:0] val);
		int lo;
		int hi;
		lo = -1;
		hi = -1;
		predicted_bytes.delete();
		case (cmd)
			OP_WRITE: begin
				// out-of-range positions are dropped; a write while off still lands
				if (idx < BUFFER_BYTES)
					frame_copy[idx] = val;
			end
			OP_REFRESH: begin
				if (!display_off_copy) begin
					for (int i = 0; i < BUFFER_BYTES; i++)
						if (frame_copy[i] != shadow_copy[i]) begin
							if (lo < 0)
								lo = i;
							hi = i;
						end
					// nothing differs: no transaction at all
					if (lo >= 0) begin
						predicted_bytes.push_back(beat(slave_addr_copy, 1'b1, 1'b0));
						predicted_bytes.push_back(beat(8'(lo * 2), 1'b0, 1'b0));
						for (int i = lo; i <= hi; i++) begin
							predicted_bytes.push_back(beat(frame_copy[i], 1'b0, i == hi));
							shadow_copy[i] = frame_copy[i];
						end
					end
				end
			end
			OP_POWER: begin
				predicted_bytes.push_back(beat(slave_addr_copy, 1'b1, 1'b0));
				predicted_bytes.push_back(beat(MODE_SET_OP |
					(display_off_copy ? MODE_DISPLAY_ON : 8'h00), 1'b0, 1'b1));
				display_off_copy = !display_off_copy;
			end
			default: ;
		endcase
	endfunction

	function automatic void add_row(logic [1:0] cmd, logic [3:0] idx, logic [7:0] val,
		logic typed, logic [1:0] n, link_beat_t b0, link_beat_t b1, link_beat_t b2);
		stim_row_t r;
		r.cmd = cmd;
		r.idx = idx;
		r.val = val;
		r.typed = typed;
		r.n_beats = n;
		r.beats[0] = b0;
		r.beats[1] = b1;
		r.beats[2] = b2;
		stim_table.push_back(r);
	endfunction

	// offer one item beat from a falling edge, wait for the handshake, then predict;
	// typed rows push their own expectation instead of the predicted one
	task automatic send_item(logic [1:0] cmd, logic [3:0] idx, logic [7:0] val,
		bit typed);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.command = cmd;
		in_ch.byte_index = idx;
		in_ch.byte_value = val;
		do
			@(posedge clk);
		while (!in_ch.ready);
		@(negedge clk);
		predict_link_bytes(cmd, idx, val);
		if (!typed)
			foreach (predicted_bytes[k])
				awaited_link_bytes.push_back(predicted_bytes[k]);
	endtask

	// block is idle once every owed beat has come and a silent scan has had time to end
	task automatic wait_link_quiet();
		in_ch.valid = 1'b0;
		while (awaited_link_bytes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_slave_address(logic [7:0] v);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		slave_addr_copy = v;
	endtask

	// results sink: ready moves at the falling edge, stalls at random outside the steady stretch
	always @(negedge clk)
		out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

	// every accepted result beat is matched against the oldest owed beat
	always @(posedge clk) begin
		link_beat_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (awaited_link_bytes.size() == 0) begin
				$display("%0t: unexpected beat, got tx_byte %02h start %0b end %0b", $time,
					out_ch.tx_byte, out_ch.frame_start, out_ch.frame_end);
				error_count++;
			end else begin
				want = awaited_link_bytes.pop_front();
				if (out_ch.tx_byte !== want.tx_byte) begin
					$display("%0t: tx_byte mismatch, expected %02h, got %02h", $time,
						want.tx_byte, out_ch.tx_byte);
					error_count++;
				end
				if (out_ch.frame_start !== want.frame_start) begin
					$display("%0t: frame_start mismatch, expected %0b, got %0b", $time,
						want.frame_start, out_ch.frame_start);
					error_count++;
				end
				if (out_ch.frame_end !== want.frame_end) begin
					$display("%0t: frame_end mismatch, expected %0b, got %0b", $time,
						want.frame_end, out_ch.frame_end);
					error_count++;
				end
			end
		end
	end

	// watchdog on a runaway or hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still owed", cycle_count,
				awaited_link_bytes.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		link_beat_t none;
		stim_row_t  r;
		int         counted;
		int         pick;
		logic [1:0] cmd;
		logic [3:0] idx;
		logic [7:0] val;
		logic [7:0] addr;

		none = beat(8'h00, 1'b0, 1'b0);
		error_count = 0;
		cycle_count = 0;
		steady = 1'b0;

		// every input known from time zero, reset held low at the start
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'h00;
		in_ch.valid = 1'b0;
		in_ch.command = OP_WRITE;
		in_ch.byte_index = 4'd0;
		in_ch.byte_value = 8'h00;
		out_ch.ready = 1'b0;

		foreach (frame_copy[i]) begin
			frame_copy[i] = 8'h00;
			shadow_copy[i] = 8'h00;
		end
		display_off_copy = 1'b0;
		slave_addr_copy = ADDR_RESET;

		// directed rows; beats typed in only where they are plain from the reset state
		// refresh straight after reset: buffers agree, nothing sent
		add_row(OP_REFRESH, 4'd0, 8'h00, 1, 0, none, none, none);
		// display off: mode-set without the on bit
		add_row(OP_POWER, 4'd0, 8'h00, 1, 2, beat(ADDR_RESET, 1, 0),
			beat(MODE_SET_OP, 0, 1), none);
		// a write while off is stored but sends nothing
		add_row(OP_WRITE, 4'd0, 8'hFF, 1, 0, none, none, none);
		// refresh while off is dropped, shadow left alone
		add_row(OP_REFRESH, 4'd0, 8'h00, 1, 0, none, none, none);
		// back on: mode-set with the on bit
		add_row(OP_POWER, 4'd0, 8'h00, 1, 2, beat(ADDR_RESET, 1, 0),
			beat(MODE_SET_OP | MODE_DISPLAY_ON, 0, 1), none);
		// the byte written while off now goes out, span of one at position 0
		add_row(OP_REFRESH, 4'd0, 8'h00, 1, 3, beat(ADDR_RESET, 1, 0), beat(8'h00, 0, 0),
			beat(8'hFF, 0, 1));
		add_row(OP_WRITE, 4'd11, 8'h80, 1, 0, none, none, none);
		// positions past the buffer are ignored
		add_row(OP_WRITE, 4'd15, 8'hAA, 1, 0, none, none, none);
		add_row(OP_WRITE, 4'd12, 8'h55, 1, 0, none, none, none);
		// unused command code is ignored
		add_row(OP_UNUSED, 4'd5, 8'h33, 1, 0, none, none, none);
		// span of one at the top position, address-set is twice the index
		add_row(OP_REFRESH, 4'd0, 8'h00, 1, 3, beat(ADDR_RESET, 1, 0), beat(8'h16, 0, 0),
			beat(8'h80, 0, 1));
		// both ends dirty: the longest transaction
		add_row(OP_WRITE, 4'd0, 8'h01, 0, 0, none, none, none);
		add_row(OP_WRITE, 4'd11, 8'h7F, 0, 0, none, none, none);
		add_row(OP_REFRESH, 4'd0, 8'h00, 0, 0, none, none, none);
		// shadow now matches
		add_row(OP_REFRESH, 4'd0, 8'h00, 1, 0, none, none, none);
		// writing the value already sent leaves nothing dirty
		add_row(OP_WRITE, 4'd5, 8'h00, 1, 0, none, none, none);
		add_row(OP_REFRESH, 4'd0, 8'h00, 1, 0, none, none, none);
		// span with clean bytes in the middle, index and value fields set but unused
		add_row(OP_WRITE, 4'd3, 8'hAA, 0, 0, none, none, none);
		add_row(OP_WRITE, 4'd8, 8'h55, 0, 0, none, none, none);
		add_row(OP_REFRESH, 4'd15, 8'hFF, 0, 0, none, none, none);
		add_row(OP_POWER, 4'd15, 8'hFF, 0, 0, none, none, none);
		add_row(OP_POWER, 4'd0, 8'h00, 0, 0, none, none, none);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (stim_table[k]) begin
			r = stim_table[k];
			send_item(r.cmd, r.idx, r.val, r.typed);
			if (r.typed)
				for (int b = 0; b < r.n_beats; b++)
					awaited_link_bytes.push_back(r.beats[b]);
		end

		// random phases, each under its own slave address; the second runs with no idling
		for (int ph = 0; ph < 4; ph++) begin
			wait_link_quiet();
			case (ph)
				0: addr = 8'h00;
				1: addr = 8'hFF;
				default: addr = 8'($urandom_range(255));
			endcase
			write_slave_address(addr);
			steady = (ph == 1);
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				pick = $urandom_range(99);
				idx = 4'($urandom_range(15));
				val = 8'($urandom_range(255));
				// bias back to on so most refreshes have something to send
				if (display_off_copy && pick < 45) begin
					cmd = OP_POWER;
				end else if (pick < 55) begin
					cmd = OP_WRITE;
					idx = 4'($urandom_range(BUFFER_BYTES - 1));
					// sometimes rewrite the current contents, which dirties nothing
					if ($urandom_range(3) == 0)
						val = frame_copy[idx];
				end else if (pick < 78) begin
					cmd = OP_REFRESH;
				end else if (pick < 86) begin
					cmd = OP_POWER;
				end else if (pick < 94) begin
					// position past the buffer, dropped by the block
					cmd = OP_WRITE;
					idx = 4'($urandom_range(15, BUFFER_BYTES));
				end else begin
					cmd = OP_UNUSED;
				end
				send_item(cmd, idx, val, 0);
				counted++;
			end
			steady = 1'b0;
		end

		wait_link_quiet();

		if (error_count == 0 && awaited_link_bytes.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== lcd_dirty_range_refresh.f =====
hdl/lcdr_pkg.sv
hdl/lcdr_in_if.sv
hdl/lcdr_out_if.sv
hdl/lcdr_dp.sv
hdl/lcdr_ctrl.sv
hdl/lcd_dirty_range_refresh.sv
tb/tb_lcd_dirty_range_refresh.sv
